>>> rtl/assert_macros.svh
// Assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/snce_pkg.sv
package snce_pkg;

  // Default geometry
  localparam int unsigned PageBytesDef     = 4352;
  localparam int unsigned PagesPerBlockDef = 64;
  localparam int unsigned NumBlocksDef     = 2;

  // Command opcodes
  localparam logic [7:0] CMD_NONE        = 8'h00;
  localparam logic [7:0] CMD_RESET       = 8'hff;
  localparam logic [7:0] CMD_GET_FEATURE = 8'h0f;
  localparam logic [7:0] CMD_SET_FEATURE = 8'h1f;
  localparam logic [7:0] CMD_PAGE_READ   = 8'h13;
  localparam logic [7:0] CMD_PROG_EXEC   = 8'h10;
  localparam logic [7:0] CMD_BLOCK_ERASE = 8'hd8;
  localparam logic [7:0] CMD_READ_ID     = 8'h9f;
  localparam logic [7:0] CMD_READ_SLOW   = 8'h03;
  localparam logic [7:0] CMD_READ_FAST   = 8'h0b;
  localparam logic [7:0] CMD_READ_X2     = 8'h3b;
  localparam logic [7:0] CMD_READ_X4     = 8'h6b;
  localparam logic [7:0] CMD_READ_DIO    = 8'hbb;
  localparam logic [7:0] CMD_READ_QIO    = 8'heb;
  localparam logic [7:0] CMD_LOAD        = 8'h02;
  localparam logic [7:0] CMD_LOAD_RAND   = 8'h84;
  localparam logic [7:0] CMD_LOAD_X4     = 8'h32;
  localparam logic [7:0] CMD_LOAD_RAND4  = 8'h34;

  // Feature register addresses
  localparam logic [7:0] FEAT_LOCK   = 8'ha0;
  localparam logic [7:0] FEAT_STATUS = 8'hc0;

  // ID bytes
  localparam logic [7:0] ID_MFR   = 8'hc8;
  localparam logic [7:0] ID_DEV0  = 8'ha4;
  localparam logic [7:0] ID_DEV1  = 8'h68;
  localparam logic [7:0] ID_TAIL  = 8'h00;
  localparam logic [7:0] IDLE_BYTE = 8'hff;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_RMW,
    S_FRD,
    S_CRD,
    S_ROWCHK,
    S_PRD,
    S_PPROG,
    S_EFIND,
    S_ECLR,
    S_DONE
  } snce_state_e;

  function automatic logic is_cache_read(input logic [7:0] c);
    return c == CMD_READ_SLOW || c == CMD_READ_FAST || c == CMD_READ_X2 ||
           c == CMD_READ_X4 || c == CMD_READ_DIO || c == CMD_READ_QIO;
  endfunction

  function automatic logic is_cache_load(input logic [7:0] c);
    return c == CMD_LOAD || c == CMD_LOAD_RAND || c == CMD_LOAD_X4 ||
           c == CMD_LOAD_RAND4;
  endfunction

  function automatic logic is_page_cmd(input logic [7:0] c);
    return c == CMD_PAGE_READ || c == CMD_PROG_EXEC || c == CMD_BLOCK_ERASE;
  endfunction

endpackage

>>> rtl/spi_nand_command_engine.sv
// A request is registered in IDLE, handled in EXEC (a cache read, a feature read or the reset
// command adds CRD, FRD or RMW) and its result loaded in DONE; only IDLE takes a new request.
// The last row byte of page read and program execute then copies the page byte by byte (a
// refused program skips it); block erase finds the block start, then clears that block's flags.
// Reset (rst_ni low, async): control clears; then a CLEAR pass fills each byte of the
// page cache with 0xff while no request is taken (config writes are still accepted).
`include "assert_macros.svh"

module spi_nand_command_engine #(
  parameter int unsigned PAGE_BYTES      = snce_pkg::PageBytesDef,
  parameter int unsigned PAGES_PER_BLOCK = snce_pkg::PagesPerBlockDef,
  parameter int unsigned NUM_BLOCKS      = snce_pkg::NumBlocksDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] data_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_out_o
);

  localparam int unsigned TOTAL_PAGES = PAGES_PER_BLOCK * NUM_BLOCKS;
  localparam longint unsigned FLASH_BYTES = longint'(TOTAL_PAGES) * longint'(PAGE_BYTES);
  localparam int unsigned CW  = $clog2(PAGE_BYTES);
  localparam int unsigned PGW = (TOTAL_PAGES > 1) ? $clog2(TOTAL_PAGES) : 1;
  localparam int unsigned BW  = (PAGES_PER_BLOCK > 1) ? $clog2(PAGES_PER_BLOCK) : 1;
  localparam int unsigned FAW = $clog2(FLASH_BYTES);

  snce_pkg::snce_state_e state_q, state_d;

  logic        present_q;
  logic        act_q, act_d;
  logic [7:0]  din_q, din_d;
  logic [7:0]  res_q, res_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [3:0]  pos_q, pos_d;
  logic [1:0]  ab_q, ab_d;
  logic        db_q, db_d;
  logic [23:0] acc_q, acc_d;
  logic [15:0] col_q, col_d;
  logic [23:0] row_q, row_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           ph_q, ph_d;
  logic           src_ok_q, src_ok_d;
  logic [FAW-1:0] fa_q, fa_d;
  logic [PGW-1:0] p_q, p_d, bs_q, bs_d;
  logic [BW-1:0]  w_q, w_d;
  logic           out_valid_q;
  logic [7:0]     out_data_q;

  // Memories and their ports
  logic [7:0] feat_mem [256];
  logic [255:0] feat_vld_q;
  logic [7:0] feat_rd_q;
  logic       feat_rvld_q;
  logic       feat_we;
  logic [7:0] feat_waddr, feat_wdata, feat_raddr, feat_val;

  logic [7:0]    cache_mem [PAGE_BYTES];
  logic [7:0]    cache_rd_q;
  logic          cache_we;
  logic [CW-1:0] cache_waddr, cache_raddr;
  logic [7:0]    cache_wdata;

  logic [7:0] flash_mem [FLASH_BYTES];
  logic [7:0] flash_rd_q;
  logic       flash_we;

  logic [TOTAL_PAGES-1:0] pflag_q;
  logic pflag_set, pflag_clr;

  logic           out_load;
  logic [3:0]     apos;
  logic [23:0]    acc_n;
  logic           row_in_range;
  logic [PGW-1:0] row_idx;
  logic           col_in_range;
  logic [15:0]    col_next;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == snce_pkg::S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign data_out_o   = out_data_q;
  assign feat_val     = feat_rvld_q ? feat_rd_q : 8'h00;
  assign apos         = pos_q - 4'd1;
  assign acc_n        = {acc_q[15:0], din_q};
  assign row_in_range = {8'h00, row_q} < 32'(TOTAL_PAGES);
  assign row_idx      = row_q[PGW-1:0];
  assign col_in_range = {16'h0000, col_q} < 32'(PAGE_BYTES);
  assign col_next     = (col_q != 16'hffff) ? col_q + 16'd1 : col_q;

  // Next state and datapath control
  always_comb begin
    state_d = state_q;
    act_d = act_q; din_d = din_q; res_d = res_q;
    cmd_d = cmd_q; pos_d = pos_q; ab_d = ab_q; db_d = db_q;
    acc_d = acc_q; col_d = col_q; row_d = row_q;
    cnt_d = cnt_q; ph_d = ph_q; src_ok_d = src_ok_q; fa_d = fa_q;
    p_d = p_q; bs_d = bs_q; w_d = w_q;
    feat_we = 1'b0;
    feat_waddr = acc_q[7:0];
    feat_wdata = din_q;
    feat_raddr = (pos_q == 4'd0) ? snce_pkg::FEAT_STATUS :
                 (cmd_q == snce_pkg::CMD_GET_FEATURE) ? acc_q[7:0] : snce_pkg::FEAT_LOCK;
    cache_we = 1'b0;
    cache_waddr = cnt_q;
    cache_wdata = snce_pkg::IDLE_BYTE;
    cache_raddr = (state_q == snce_pkg::S_PPROG) ? cnt_q : col_q[CW-1:0];
    flash_we = 1'b0;
    pflag_set = 1'b0;
    pflag_clr = 1'b0;
    out_load = 1'b0;

    case (state_q)
      snce_pkg::S_CLEAR: begin
        cache_we = 1'b1;
        if (cnt_q == CW'(PAGE_BYTES - 1)) begin
          cnt_d = '0;
          state_d = snce_pkg::S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      snce_pkg::S_IDLE: begin
        if (in_valid_i) begin
          act_d = action_i;
          din_d = data_in_i;
          state_d = snce_pkg::S_EXEC;
        end
      end
      snce_pkg::S_EXEC: begin
        res_d = snce_pkg::IDLE_BYTE;
        state_d = snce_pkg::S_DONE;
        if (act_q) begin
          // chip select end
          pos_d = 4'd0;
          cmd_d = snce_pkg::CMD_NONE;
        end else if (pos_q == 4'd0) begin
          // command decode
          cmd_d = din_q;
          pos_d = 4'd1;
          ab_d = 2'd0;
          db_d = 1'b0;
          acc_d = '0;
          if (din_q == snce_pkg::CMD_RESET) begin
            state_d = snce_pkg::S_RMW;
          end else if (din_q == snce_pkg::CMD_GET_FEATURE ||
                       din_q == snce_pkg::CMD_SET_FEATURE) begin
            ab_d = 2'd1;
          end else if (snce_pkg::is_page_cmd(din_q)) begin
            ab_d = 2'd3;
          end else if (din_q == snce_pkg::CMD_READ_SLOW || snce_pkg::is_cache_load(din_q)) begin
            ab_d = 2'd2;
          end else if (snce_pkg::is_cache_read(din_q)) begin
            ab_d = 2'd2;
            db_d = 1'b1;
          end
        end else if (apos < {2'b00, ab_q}) begin
          // address byte
          acc_d = acc_n;
          pos_d = pos_q + 4'd1;
          if (apos + 4'd1 == {2'b00, ab_q}) begin
            if (snce_pkg::is_page_cmd(cmd_q)) begin
              row_d = acc_n;
              state_d = snce_pkg::S_ROWCHK;
            end else if (snce_pkg::is_cache_read(cmd_q) || snce_pkg::is_cache_load(cmd_q)) begin
              col_d = acc_n[15:0];
            end
          end
        end else if (apos < ({2'b00, ab_q} + {3'b000, db_q})) begin
          // dummy byte
          pos_d = pos_q + 4'd1;
        end else begin
          // data phase
          if (pos_q != 4'd15) pos_d = pos_q + 4'd1;
          if (cmd_q == snce_pkg::CMD_READ_ID) begin
            res_d = (apos == 4'd0) ? snce_pkg::ID_MFR :
                    (apos == 4'd1) ? snce_pkg::ID_DEV0 :
                    (apos == 4'd2) ? snce_pkg::ID_DEV1 : snce_pkg::ID_TAIL;
          end else if (cmd_q == snce_pkg::CMD_GET_FEATURE) begin
            state_d = snce_pkg::S_FRD;
          end else if (cmd_q == snce_pkg::CMD_SET_FEATURE) begin
            feat_we = 1'b1;
          end else if (snce_pkg::is_cache_read(cmd_q)) begin
            if (col_in_range) state_d = snce_pkg::S_CRD;
            col_d = col_next;
          end else if (snce_pkg::is_cache_load(cmd_q)) begin
            if (col_in_range) begin
              cache_we = 1'b1;
              cache_waddr = col_q[CW-1:0];
              cache_wdata = din_q;
            end
            col_d = col_next;
          end
        end
      end
      snce_pkg::S_RMW: begin
        // clear busy bit of status
        feat_we = 1'b1;
        feat_waddr = snce_pkg::FEAT_STATUS;
        feat_wdata = feat_val & 8'hfe;
        state_d = snce_pkg::S_DONE;
      end
      snce_pkg::S_FRD: begin
        res_d = feat_val;
        state_d = snce_pkg::S_DONE;
      end
      snce_pkg::S_CRD: begin
        res_d = cache_rd_q;
        state_d = snce_pkg::S_DONE;
      end
      snce_pkg::S_ROWCHK: begin
        fa_d = FAW'(FAW'(row_idx) * FAW'(PAGE_BYTES));
        cnt_d = '0;
        ph_d = 1'b0;
        p_d = '0;
        bs_d = '0;
        w_d = '0;
        state_d = snce_pkg::S_DONE;
        if (cmd_q == snce_pkg::CMD_PAGE_READ) begin
          src_ok_d = present_q && row_in_range && pflag_q[row_idx];
          state_d = snce_pkg::S_PRD;
        end else if (cmd_q == snce_pkg::CMD_PROG_EXEC) begin
          if (present_q && feat_val == 8'h00 && row_in_range) state_d = snce_pkg::S_PPROG;
        end else if (cmd_q == snce_pkg::CMD_BLOCK_ERASE) begin
          if (present_q && row_in_range) state_d = snce_pkg::S_EFIND;
        end
      end
      snce_pkg::S_PRD: begin
        // flash -> cache, read then write per byte
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          cache_we = 1'b1;
          cache_wdata = src_ok_q ? flash_rd_q : snce_pkg::IDLE_BYTE;
          fa_d = fa_q + 1'b1;
          if (cnt_q == CW'(PAGE_BYTES - 1)) state_d = snce_pkg::S_DONE;
          else cnt_d = cnt_q + 1'b1;
        end
      end
      snce_pkg::S_PPROG: begin
        // cache -> flash
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          flash_we = 1'b1;
          fa_d = fa_q + 1'b1;
          if (cnt_q == CW'(PAGE_BYTES - 1)) begin
            pflag_set = 1'b1;
            state_d = snce_pkg::S_DONE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      snce_pkg::S_EFIND: begin
        // walk pages to find the block start of the row
        if (p_q == row_idx) begin
          p_d = bs_q;
          w_d = '0;
          state_d = snce_pkg::S_ECLR;
        end else begin
          p_d = p_q + 1'b1;
          if (w_q == BW'(PAGES_PER_BLOCK - 1)) begin
            w_d = '0;
            bs_d = p_q + 1'b1;
          end else begin
            w_d = w_q + 1'b1;
          end
        end
      end
      snce_pkg::S_ECLR: begin
        pflag_clr = 1'b1;
        if (w_q == BW'(PAGES_PER_BLOCK - 1)) begin
          state_d = snce_pkg::S_DONE;
        end else begin
          p_d = p_q + 1'b1;
          w_d = w_q + 1'b1;
        end
      end
      snce_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d = snce_pkg::S_IDLE;
        end
      end
      default: state_d = snce_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= snce_pkg::S_CLEAR;
      present_q <= 1'b1;
      cmd_q <= '0; pos_q <= '0; ab_q <= '0; db_q <= 1'b0;
      acc_q <= '0; col_q <= '0; row_q <= '0;
      cnt_q <= '0; ph_q <= 1'b0;
      p_q <= '0; bs_q <= '0; w_q <= '0;
      out_valid_q <= 1'b0;
      feat_vld_q <= '0;
      pflag_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) present_q <= cfg_data_i;
      cmd_q <= cmd_d; pos_q <= pos_d; ab_q <= ab_d; db_q <= db_d;
      acc_q <= acc_d; col_q <= col_d; row_q <= row_d;
      cnt_q <= cnt_d; ph_q <= ph_d;
      p_q <= p_d; bs_q <= bs_d; w_q <= w_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (feat_we) feat_vld_q[feat_waddr] <= 1'b1;
      if (pflag_set) pflag_q[row_idx] <= 1'b1;
      if (pflag_clr) pflag_q[p_q] <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    din_q <= din_d;
    res_q <= res_d;
    src_ok_q <= src_ok_d;
    fa_q <= fa_d;
    if (out_load) out_data_q <= res_q;
  end

  // Feature register memory
  always_ff @(posedge clk_i) begin
    if (feat_we) feat_mem[feat_waddr] <= feat_wdata;
    feat_rd_q <= feat_mem[feat_raddr];
    feat_rvld_q <= feat_vld_q[feat_raddr];
  end

  // Page cache memory
  always_ff @(posedge clk_i) begin
    if (cache_we) cache_mem[cache_waddr] <= cache_wdata;
    cache_rd_q <= cache_mem[cache_raddr];
  end

  // Flash array memory
  always_ff @(posedge clk_i) begin
    if (flash_we) flash_mem[fa_q] <= cache_rd_q;
    flash_rd_q <= flash_mem[fa_q];
  end

  `ASSERT_NXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o,
              "request accepted while previous one in flight")
  `ASSERT_IMP(a_cache_wr_range, cache_we, 32'(cache_waddr) < 32'(PAGE_BYTES),
              "page cache write past end")
  `ASSERT_IMP(a_flash_wr_prog, flash_we, state_q == snce_pkg::S_PPROG,
              "flash written outside program execute")
  `ASSERT_IMP(a_out_only_done, out_load, state_q == snce_pkg::S_DONE,
              "output loaded outside done")

endmodule

>>> bench/spi_nand_command_engine_tb.sv
`timescale 1ns / 100ps

module spi_nand_command_engine_tb;

  localparam int unsigned PAGE_SZ   = snce_pkg::PageBytesDef;
  localparam int unsigned BLK_PAGES = snce_pkg::PagesPerBlockDef;
  localparam int unsigned NBLK      = snce_pkg::NumBlocksDef;
  localparam int unsigned NPAGES    = BLK_PAGES * NBLK;
  localparam int unsigned ARRAY_SZ  = PAGE_SZ * NPAGES;
  localparam int unsigned STALL_MAX = 40000;
  localparam logic [7:0]  CMD_WREN  = 8'h06;
  localparam logic [7:0]  CMD_WRDI  = 8'h04;
  localparam logic [7:0]  CMD_BOGUS = 8'h55;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_data_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       action_i = 1'b0;
  logic [7:0] data_in_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] data_out_o;

  spi_nand_command_engine i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .action_i, .data_in_i,
    .out_valid_o, .out_ready_i, .data_out_o
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the flash engine
  logic       storage_on;
  logic [7:0] cmd_q;
  int         pos_q;
  int         naddr_q;
  int         ndummy_q;
  logic [23:0] addr_acc;
  logic [15:0] col_q;
  logic [23:0] row_q;
  logic [7:0] feat_mem [256];
  logic [7:0] cache_mem [PAGE_SZ];
  logic [7:0] flash_mem [ARRAY_SZ];

  logic [7:0] expected_bytes [$];
  int         err_count = 0;
  int         stall_cnt = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic bit cmd_is_cache_read(input logic [7:0] c);
    return c == snce_pkg::CMD_READ_SLOW || c == snce_pkg::CMD_READ_FAST ||
           c == snce_pkg::CMD_READ_X2 || c == snce_pkg::CMD_READ_X4 ||
           c == snce_pkg::CMD_READ_DIO || c == snce_pkg::CMD_READ_QIO;
  endfunction

  function automatic bit cmd_is_cache_load(input logic [7:0] c);
    return c == snce_pkg::CMD_LOAD || c == snce_pkg::CMD_LOAD_RAND ||
           c == snce_pkg::CMD_LOAD_X4 || c == snce_pkg::CMD_LOAD_RAND4;
  endfunction

  function automatic bit cmd_is_page(input logic [7:0] c);
    return c == snce_pkg::CMD_PAGE_READ || c == snce_pkg::CMD_PROG_EXEC ||
           c == snce_pkg::CMD_BLOCK_ERASE;
  endfunction

  function automatic void flash_reset();
    storage_on = 1'b1;
    cmd_q = snce_pkg::CMD_NONE;
    pos_q = 0;
    naddr_q = 0;
    ndummy_q = 0;
    addr_acc = '0;
    col_q = '0;
    row_q = '0;
    foreach (feat_mem[i]) feat_mem[i] = 8'h00;
    foreach (cache_mem[i]) cache_mem[i] = 8'hff;
    foreach (flash_mem[i]) flash_mem[i] = 8'hff;
  endfunction

  // Page read / program / erase once the row is in
  function automatic void run_page_op();
    int unsigned blk;
    row_q = addr_acc;
    if (cmd_q == snce_pkg::CMD_PAGE_READ) begin
      for (int i = 0; i < PAGE_SZ; i++)
        cache_mem[i] = (storage_on && row_q < NPAGES) ? flash_mem[row_q * PAGE_SZ + i] : 8'hff;
    end else if (cmd_q == snce_pkg::CMD_PROG_EXEC) begin
      if (storage_on && feat_mem[snce_pkg::FEAT_LOCK] == 8'h00 && row_q < NPAGES)
        for (int i = 0; i < PAGE_SZ; i++) flash_mem[row_q * PAGE_SZ + i] = cache_mem[i];
    end else begin
      blk = row_q / BLK_PAGES;
      if (storage_on && blk < NBLK)
        for (int i = 0; i < BLK_PAGES * PAGE_SZ; i++)
          flash_mem[blk * BLK_PAGES * PAGE_SZ + i] = 8'hff;
    end
  endfunction

  function automatic logic [7:0] flash_step(input logic act, input logic [7:0] b);
    int dpos;
    logic [7:0] res;
    res = snce_pkg::IDLE_BYTE;
    if (act) begin
      pos_q = 0;
      cmd_q = snce_pkg::CMD_NONE;
      return snce_pkg::IDLE_BYTE;
    end
    if (pos_q == 0) begin
      cmd_q = b;
      pos_q = 1;
      naddr_q = 0;
      ndummy_q = 0;
      addr_acc = '0;
      if (b == snce_pkg::CMD_RESET) feat_mem[snce_pkg::FEAT_STATUS][0] = 1'b0;
      else if (b == snce_pkg::CMD_GET_FEATURE || b == snce_pkg::CMD_SET_FEATURE) naddr_q = 1;
      else if (cmd_is_page(b)) naddr_q = 3;
      else if (b == snce_pkg::CMD_READ_SLOW || cmd_is_cache_load(b)) naddr_q = 2;
      else if (cmd_is_cache_read(b)) begin
        naddr_q = 2;
        ndummy_q = 1;
      end
      return snce_pkg::IDLE_BYTE;
    end
    dpos = pos_q - 1;
    if (dpos < naddr_q) begin
      addr_acc = {addr_acc[15:0], b};
      pos_q++;
      if (dpos + 1 == naddr_q) begin
        if (cmd_is_page(cmd_q))
          run_page_op();
        else if (cmd_is_cache_read(cmd_q) || cmd_is_cache_load(cmd_q))
          col_q = addr_acc[15:0];
      end
      return snce_pkg::IDLE_BYTE;
    end
    if (dpos < naddr_q + ndummy_q) begin
      pos_q++;
      return snce_pkg::IDLE_BYTE;
    end
    // data phase
    if (cmd_q == snce_pkg::CMD_READ_ID) begin
      res = dpos == 0 ? snce_pkg::ID_MFR : dpos == 1 ? snce_pkg::ID_DEV0 :
            dpos == 2 ? snce_pkg::ID_DEV1 : snce_pkg::ID_TAIL;
    end else if (cmd_q == snce_pkg::CMD_GET_FEATURE) begin
      res = feat_mem[addr_acc[7:0]];
    end else if (cmd_q == snce_pkg::CMD_SET_FEATURE) begin
      feat_mem[addr_acc[7:0]] = b;
    end else if (cmd_is_cache_read(cmd_q)) begin
      res = col_q < PAGE_SZ ? cache_mem[col_q] : 8'hff;
      if (col_q != 16'hffff) col_q++;
    end else if (cmd_is_cache_load(cmd_q)) begin
      if (col_q < PAGE_SZ) cache_mem[col_q] = b;
      if (col_q != 16'hffff) col_q++;
    end
    if (pos_q < 15) pos_q++;
    return res;
  endfunction

  // Receiver back-pressure
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  // Result check against the oldest expected byte
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", data_out_o));
      end else begin
        if (data_out_o !== expected_bytes[0])
          report_mismatch($sformatf("data_out %02h, want %02h", data_out_o, expected_bytes[0]));
        void'(expected_bytes.pop_front());
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt > STALL_MAX) begin
      $display("watchdog expired at %0t", $realtime);
      $display("FAILURE");
      $finish;
    end
  end

  // One byte request (or chip-select end) with random sender gaps
  task automatic send_request(input logic act, input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    data_in_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    expected_bytes.push_back(flash_step(act, b));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_storage(input logic v);
    drain();
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    storage_on = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int addr_len(input logic [7:0] c);
    if (c == snce_pkg::CMD_GET_FEATURE || c == snce_pkg::CMD_SET_FEATURE) return 1;
    if (cmd_is_page(c)) return 3;
    if (cmd_is_cache_read(c) || cmd_is_cache_load(c)) return 2;
    return 0;
  endfunction

  // Full transaction: command, address, dummy, data bytes, chip-select end
  task automatic run_xact(input logic [7:0] c, input logic [23:0] a, input int ndata,
                          input bit close = 1'b1);
    int na;
    na = addr_len(c);
    send_request(1'b0, c);
    for (int i = na - 1; i >= 0; i--) send_request(1'b0, a[i*8 +: 8]);
    if (cmd_is_cache_read(c) && c != snce_pkg::CMD_READ_SLOW)
      send_request(1'b0, 8'($urandom_range(255)));
    for (int i = 0; i < ndata; i++) send_request(1'b0, 8'($urandom_range(255)));
    if (close) send_request(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic test_directed();
    run_xact(snce_pkg::CMD_READ_ID, 24'd0, 5);
    run_xact(snce_pkg::CMD_SET_FEATURE, 24'(snce_pkg::FEAT_STATUS), 1);
    run_xact(snce_pkg::CMD_RESET, 24'd0, 0);
    run_xact(snce_pkg::CMD_GET_FEATURE, 24'(snce_pkg::FEAT_STATUS), 1);
    run_xact(CMD_BOGUS, 24'd0, 2);
    run_xact(CMD_WREN, 24'd0, 0);
    run_xact(CMD_WRDI, 24'd0, 0);
    run_xact(snce_pkg::CMD_LOAD, 24'd0, 3);
    run_xact(snce_pkg::CMD_PROG_EXEC, 24'd1, 0);
    run_xact(snce_pkg::CMD_PAGE_READ, 24'd1, 0);
    run_xact(snce_pkg::CMD_READ_FAST, 24'd0, 3);
    run_xact(snce_pkg::CMD_READ_SLOW, 24'(PAGE_SZ - 1), 2);
    run_xact(snce_pkg::CMD_LOAD_RAND, 24'h00fffe, 3);
    run_xact(snce_pkg::CMD_READ_ID, 24'd0, 16);
  endtask

  task automatic test_lock_and_erase();
    run_xact(snce_pkg::CMD_LOAD_X4, 24'd5, 2);
    run_xact(snce_pkg::CMD_SET_FEATURE, 24'(snce_pkg::FEAT_LOCK), 0, 1'b0);
    send_request(1'b0, 8'h38);
    send_request(1'b1, 8'h00);
    run_xact(snce_pkg::CMD_PROG_EXEC, 24'd2, 0);
    run_xact(snce_pkg::CMD_SET_FEATURE, 24'(snce_pkg::FEAT_LOCK), 0, 1'b0);
    send_request(1'b0, 8'h00);
    send_request(1'b1, 8'h00);
    run_xact(snce_pkg::CMD_PROG_EXEC, 24'd3, 0);
    run_xact(snce_pkg::CMD_PAGE_READ, 24'hffffff, 0);
    run_xact(snce_pkg::CMD_PAGE_READ, 24'd3, 0);
    run_xact(snce_pkg::CMD_READ_QIO, 24'd4, 3);
    run_xact(snce_pkg::CMD_BLOCK_ERASE, 24'd64 + 24'd3, 0);
    run_xact(snce_pkg::CMD_BLOCK_ERASE, 24'd0, 0);
    run_xact(snce_pkg::CMD_PAGE_READ, 24'd3, 0);
    run_xact(snce_pkg::CMD_READ_X2, 24'd4, 2);
  endtask

  task automatic test_no_storage();
    write_storage(1'b0);
    run_xact(snce_pkg::CMD_LOAD, 24'd0, 2);
    run_xact(snce_pkg::CMD_PROG_EXEC, 24'd5, 0);
    run_xact(snce_pkg::CMD_BLOCK_ERASE, 24'd64, 0);
    run_xact(snce_pkg::CMD_PAGE_READ, 24'd1, 0);
    run_xact(snce_pkg::CMD_READ_X4, 24'd0, 2);
    write_storage(1'b1);
    run_xact(snce_pkg::CMD_PAGE_READ, 24'd1, 0);
    run_xact(snce_pkg::CMD_READ_DIO, 24'd0, 2);
  endtask

  function automatic logic [23:0] pick_col();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 24'($urandom_range(31));
    if (r < 80) return 24'(PAGE_SZ - 4 + $urandom_range(7));
    if (r < 90) return 24'(16'hfff0 + $urandom_range(15));
    return 24'($urandom_range(16'hffff));
  endfunction

  function automatic logic [23:0] pick_row();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 24'(($urandom_range(1) ? 64 : 0) + $urandom_range(3));
    if (r < 90) return 24'($urandom_range(NPAGES - 1));
    return 24'($urandom_range(24'hffffff));
  endfunction

  // Mostly well-formed transactions with random content, some noise
  task automatic test_random(input int n_bytes);
    int r;
    logic [7:0] reads [6];
    logic [7:0] loads [4];
    reads = '{snce_pkg::CMD_READ_SLOW, snce_pkg::CMD_READ_FAST, snce_pkg::CMD_READ_X2,
              snce_pkg::CMD_READ_X4, snce_pkg::CMD_READ_DIO, snce_pkg::CMD_READ_QIO};
    loads = '{snce_pkg::CMD_LOAD, snce_pkg::CMD_LOAD_RAND, snce_pkg::CMD_LOAD_X4,
              snce_pkg::CMD_LOAD_RAND4};
    for (int got = 0; got < n_bytes; ) begin
      r = $urandom_range(99);
      if (r < 25) begin
        run_xact(reads[$urandom_range(5)], pick_col(), $urandom_range(8));
        got += 8;
      end else if (r < 50) begin
        run_xact(loads[$urandom_range(3)], pick_col(), $urandom_range(8));
        got += 8;
      end else if (r < 58) begin
        run_xact(snce_pkg::CMD_GET_FEATURE,
                 $urandom_range(1) ? 24'(snce_pkg::FEAT_STATUS) : 24'($urandom_range(255)),
                 $urandom_range(3));
        got += 4;
      end else if (r < 64) begin
        // lock writes stay zero most of the time so programs go through
        run_xact(snce_pkg::CMD_SET_FEATURE,
                 $urandom_range(3) == 0 ? 24'(snce_pkg::FEAT_LOCK) : 24'($urandom_range(255)),
                 0, 1'b0);
        send_request(1'b0, $urandom_range(3) == 0 ? 8'($urandom_range(255)) : 8'h00);
        send_request(1'b1, 8'($urandom_range(255)));
        got += 4;
      end else if (r < 71) begin
        case ($urandom_range(2))
          0: run_xact(snce_pkg::CMD_PAGE_READ, pick_row(), 0);
          1: run_xact(snce_pkg::CMD_PROG_EXEC, pick_row(), 0);
          default: run_xact(snce_pkg::CMD_BLOCK_ERASE, pick_row(), 0);
        endcase
        got += 5;
      end else if (r < 76) begin
        run_xact(snce_pkg::CMD_READ_ID, 24'd0, $urandom_range(18));
        got += 6;
      end else if (r < 84) begin
        run_xact($urandom_range(1) ? snce_pkg::CMD_RESET : 8'($urandom_range(255)),
                 24'($urandom_range(255)), $urandom_range(4), $urandom_range(3) != 0);
        got += 3;
      end else begin
        // noise and cut-off transactions
        repeat ($urandom_range(1, 5)) begin
          send_request($urandom_range(3) == 0, 8'($urandom_range(255)));
          got++;
        end
      end
    end
  endtask

  initial begin
    flash_reset();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_lock_and_erase();
    drain();
    test_no_storage();

    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(170);
    drain();
    send_idle_pct = 53; recv_stall_pct = 0;  test_random(170);
    write_storage(1'b0);
    send_idle_pct = 0;  recv_stall_pct = 53; test_random(120);
    write_storage(1'b1);
    send_idle_pct = 24; recv_stall_pct = 24; test_random(170);

    drain();
    repeat (50) @(posedge clk_i);
    if (err_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/snce_pkg.sv
rtl/spi_nand_command_engine.sv
bench/spi_nand_command_engine_tb.sv
